// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL files of the maintenance queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define SMQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that one condition implies another in the same cycle.
`define SMQ_ASSERT_IMP(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) else $error(msg);

`endif

// ===== hw/rtl/smq_pkg.sv =====
// ----------------------------------------------------------------------------
// smq_pkg
// Types, codes and helpers of the scored maintenance queue.
// ----------------------------------------------------------------------------
package smq_pkg;

  localparam int QueueDepthDef = 256;
  localparam int TableCountDef = 256;

  localparam logic [63:0] SatMax        = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] GapCap        = 64'd1073741824;
  localparam logic [31:0] DefaultWeight = 32'd65536;

  localparam int CfgDataW = 32;
  localparam int CfgIdxW  = 3;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegMinInterval = 3'd0;
  localparam logic [CfgIdxW-1:0] RegQueueCap    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegUseHealth   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegSlotWeight  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegGapEnable   = 3'd4;

  // command codes
  localparam logic [1:0] CmdTrigger = 2'd0;
  localparam logic [1:0] CmdTake    = 2'd1;
  localparam logic [1:0] CmdFinish  = 2'd2;

  // status codes
  localparam logic [2:0] StQueued     = 3'd0;
  localparam logic [2:0] StCooldown   = 3'd1;
  localparam logic [2:0] StPending    = 3'd2;
  localparam logic [2:0] StFull       = 3'd3;
  localparam logic [2:0] StDispatched = 3'd4;
  localparam logic [2:0] StEmpty      = 3'd5;
  localparam logic [2:0] StFinished   = 3'd6;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  table_id;
    logic [31:0] now_sec;
    logic [63:0] size_bytes;
    logic        health_valid;
    logic [63:0] dead_space;
    logic [31:0] tomb_slots;
    logic [19:0] tomb_ratio_micro;
    logic [63:0] lsn_last_vac;
    logic [63:0] lsn_now;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  out_table;
    logic [63:0] out_score;
    logic [63:0] bonus_term;
    logic [30:0] gap_term;
    logic [8:0]  queue_depth;
    logic [8:0]  depth_peak;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  tbl;
    logic [63:0] score;
  } qent_t;

  typedef enum logic [2:0] {
    DpNone, DpMul, DpDead, DpRatio, DpSize, DpGap
  } dp_step_e;

  typedef enum logic [2:0] {
    CmQueue, CmRefuse, CmTake, CmEmpty, CmFinish
  } commit_e;

  typedef struct packed {
    logic     load;
    dp_step_e step;
    logic     walk;
    logic     shift;
    logic     shift_init;
    logic     commit;
    commit_e  kind;
  } smq_ctl_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       trig_ok;
    logic       q_empty;
    logic       walk_done;
    logic       out_busy;
  } smq_sts_t;

  function automatic logic [63:0] sadd(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? SatMax : s[63:0];
  endfunction

endpackage

// ===== hw/rtl/scored_maintenance_queue_unit.sv =====
// Steps: a trigger is read, checked and scored (multiply, dead space, ratio, size, gap);
//   finish, refused trigger and take on an empty queue commit right after the check;
//   take makes a scan pass then a compaction pass, one queue memory read per cycle.
// Throughput: one item at a time; next item is taken once the result is registered.
// Reset: asynchronous, clears depth, peak, pending and run flags at once; no clearing
//   pass. Configuration returns to its defaults.
// ----------------------------------------------------------------------------
// scored_maintenance_queue_unit
// Priority queue of maintenance requests with per-table cooldown and scoring.
// ----------------------------------------------------------------------------
module scored_maintenance_queue_unit #(
  parameter int QUEUE_DEPTH = smq_pkg::QueueDepthDef,
  parameter int TABLE_COUNT = smq_pkg::TableCountDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration writes
  input  logic                         cfg_we_i,
  input  logic [smq_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [smq_pkg::CfgDataW-1:0] cfg_data_i,
  // input beats
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  smq_pkg::in_item_t            in_item_i,
  // result beats
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output smq_pkg::out_item_t           out_item_o
);

  smq_pkg::smq_ctl_t ctl;
  smq_pkg::smq_sts_t sts;

  // Sequencer: load the beat, read the table's last run time, decide, then
  // either run the score steps, walk the queue, or go straight to commit.
  smq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  // Datapath: holds the registers, flags, queue memory and result register.
  smq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TABLE_COUNT (TABLE_COUNT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_item_i   (in_item_i),
    .out_item_o  (out_item_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ctl_i       (ctl),
    .sts_o       (sts)
  );

endmodule

// ===== hw/rtl/smq_ctrl.sv =====
// ----------------------------------------------------------------------------
// smq_ctrl
// Sequencer of the maintenance queue: steps each item through the datapath.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module smq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  smq_pkg::smq_sts_t sts_i,
  output smq_pkg::smq_ctl_t ctl_o
);

  typedef enum logic [3:0] {
    SIdle, SRead, SCheck, SMul, SDead, SRatio, SSize, SGap,
    SScan, SShiftInit, SShift, SCommit
  } state_e;

  state_e           state_q;
  smq_pkg::commit_e kind_q;

  assign in_ready_o = (state_q == SIdle);

  always_comb begin
    ctl_o            = '0;
    ctl_o.step       = smq_pkg::DpNone;
    ctl_o.kind       = kind_q;
    ctl_o.load       = (state_q == SIdle) && in_valid_i;
    ctl_o.walk       = (state_q == SScan) || (state_q == SShift);
    ctl_o.shift      = (state_q == SShift);
    ctl_o.shift_init = (state_q == SShiftInit);
    ctl_o.commit     = (state_q == SCommit) && !sts_i.out_busy;
    case (state_q)
      SMul:    ctl_o.step = smq_pkg::DpMul;
      SDead:   ctl_o.step = smq_pkg::DpDead;
      SRatio:  ctl_o.step = smq_pkg::DpRatio;
      SSize:   ctl_o.step = smq_pkg::DpSize;
      SGap:    ctl_o.step = smq_pkg::DpGap;
      default: ctl_o.step = smq_pkg::DpNone;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      kind_q  <= smq_pkg::CmEmpty;
    end else begin
      case (state_q)
        SIdle: begin
          if (in_valid_i) state_q <= SRead;
        end
        SRead: state_q <= SCheck;
        SCheck: begin
          case (sts_i.cmd)
            smq_pkg::CmdTrigger: begin
              if (sts_i.trig_ok) begin
                state_q <= SMul;
              end else begin
                kind_q  <= smq_pkg::CmRefuse;
                state_q <= SCommit;
              end
            end
            smq_pkg::CmdTake: begin
              if (sts_i.q_empty) begin
                kind_q  <= smq_pkg::CmEmpty;
                state_q <= SCommit;
              end else begin
                state_q <= SScan;
              end
            end
            smq_pkg::CmdFinish: begin
              kind_q  <= smq_pkg::CmFinish;
              state_q <= SCommit;
            end
            default: state_q <= SIdle;
          endcase
        end
        SMul:   state_q <= SDead;
        SDead:  state_q <= SRatio;
        SRatio: state_q <= SSize;
        SSize:  state_q <= SGap;
        SGap: begin
          kind_q  <= smq_pkg::CmQueue;
          state_q <= SCommit;
        end
        SScan: begin
          if (sts_i.walk_done) state_q <= SShiftInit;
        end
        SShiftInit: state_q <= SShift;
        SShift: begin
          if (sts_i.walk_done) begin
            kind_q  <= smq_pkg::CmTake;
            state_q <= SCommit;
          end
        end
        SCommit: begin
          if (!sts_i.out_busy) state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  `SMQ_ASSERT_IMP(a_commit_free, ctl_o.commit, !sts_i.out_busy, "commit into a busy output")
  `SMQ_ASSERT_IMP(a_load_idle, ctl_o.load, $past(state_q) != SRead || state_q == SIdle,
                  "item loaded outside idle")
  `SMQ_ASSERT(a_walk_excl, !(ctl_o.walk && ctl_o.commit), "queue walk overlaps commit")

endmodule

// ===== hw/rtl/smq_dp.sv =====
// ----------------------------------------------------------------------------
// smq_dp
// Datapath: configuration, table flags, queue memory, score arithmetic.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module smq_dp #(
  parameter int QUEUE_DEPTH = smq_pkg::QueueDepthDef,
  parameter int TABLE_COUNT = smq_pkg::TableCountDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [smq_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [smq_pkg::CfgDataW-1:0] cfg_data_i,
  input  smq_pkg::in_item_t            in_item_i,
  output smq_pkg::out_item_t           out_item_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  input  smq_pkg::smq_ctl_t            ctl_i,
  output smq_pkg::smq_sts_t            sts_o
);

  localparam int QW   = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam int TblW = $clog2(TABLE_COUNT);

  // configuration
  logic [15:0] min_int_q;
  logic [8:0]  cap_q;
  logic        use_health_q;
  logic [31:0] weight_q;
  logic        gap_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_int_q    <= '0;
      cap_q        <= 9'd256;
      use_health_q <= 1'b0;
      weight_q     <= smq_pkg::DefaultWeight;
      gap_en_q     <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        smq_pkg::RegMinInterval: min_int_q    <= cfg_data_i[15:0];
        smq_pkg::RegQueueCap:    cap_q        <= cfg_data_i[8:0];
        smq_pkg::RegUseHealth:   use_health_q <= cfg_data_i[0];
        smq_pkg::RegSlotWeight:  weight_q     <= cfg_data_i;
        smq_pkg::RegGapEnable:   gap_en_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // table index reduction, worked out at elaboration
  logic [TblW-1:0] mod_lut [256];
  for (genvar k = 0; k < 256; k++) begin : g_mod
    assign mod_lut[k] = TblW'(k % TABLE_COUNT);
  end

  smq_pkg::in_item_t item_q;
  logic [TblW-1:0]   tidx;
  assign tidx = mod_lut[item_q.table_id];

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) item_q <= in_item_i;
  end

  // per-table flags and last run time
  logic        pend_q [TABLE_COUNT];
  logic        run_q  [TABLE_COUNT];
  logic [31:0] lrt_mem [TABLE_COUNT];
  logic [31:0] lrt_rd_q;
  logic        pend_rd_q, run_rd_q;

  // queue state
  smq_pkg::qent_t q_mem [QUEUE_DEPTH];
  smq_pkg::qent_t rdata_q;
  logic [CntW-1:0] count_q, peak_q, count_d, peak_d;
  logic [CntW-1:0] ridx_q;
  logic [QW-1:0]   pos_q, best_idx_q;
  logic            rv_q;
  logic [7:0]      best_tab_q;
  logic [63:0]     best_score_q;
  logic            issue;

  // score registers
  logic [63:0] prod_q, bonus_q, score_q, gap_q;
  logic        health_on;
  logic [31:0] weight_eff;
  logic [63:0] lsn_diff, gap_val;
  logic        gap_on;

  assign health_on  = use_health_q && item_q.health_valid;
  assign weight_eff = (weight_q == '0) ? smq_pkg::DefaultWeight : weight_q;
  assign lsn_diff   = item_q.lsn_now - item_q.lsn_last_vac;
  assign gap_on     = health_on && gap_en_q && (item_q.lsn_now != '0) &&
                      (item_q.lsn_last_vac != '0) && (item_q.lsn_now > item_q.lsn_last_vac);
  assign gap_val    = (lsn_diff > smq_pkg::GapCap) ? smq_pkg::GapCap : lsn_diff;

  always_ff @(posedge clk_i) begin
    case (ctl_i.step)
      smq_pkg::DpMul: prod_q <= 64'(item_q.tomb_slots) * 64'(weight_eff);
      smq_pkg::DpDead: bonus_q <= health_on ? smq_pkg::sadd(item_q.dead_space, prod_q) : '0;
      smq_pkg::DpRatio: begin
        if (health_on) bonus_q <= smq_pkg::sadd(bonus_q, 64'(item_q.tomb_ratio_micro));
      end
      smq_pkg::DpSize: begin
        score_q <= smq_pkg::sadd(item_q.size_bytes, bonus_q);
        gap_q   <= gap_on ? gap_val : '0;
      end
      smq_pkg::DpGap: score_q <= smq_pkg::sadd(score_q, gap_q);
      default: ;
    endcase
  end

  // trigger decision
  logic [31:0]     now_gap;
  logic            cool_hit, full;
  logic [31:0]     cap_eff;
  logic [2:0]      trig_code;

  assign now_gap  = item_q.now_sec - lrt_rd_q;
  assign cool_hit = run_rd_q && (min_int_q != '0) && (item_q.now_sec >= lrt_rd_q) &&
                    (now_gap < 32'(min_int_q));
  assign cap_eff  = ((cap_q == '0) || (32'(cap_q) > 32'(QUEUE_DEPTH))) ?
                    32'(QUEUE_DEPTH) : 32'(cap_q);
  assign full     = 32'(count_q) >= cap_eff;

  always_comb begin
    if (cool_hit)            trig_code = smq_pkg::StCooldown;
    else if (pend_rd_q)      trig_code = smq_pkg::StPending;
    else if (full)           trig_code = smq_pkg::StFull;
    else                     trig_code = smq_pkg::StQueued;
  end

  // walk over the queue: scan for the best entry, then close the gap
  assign issue = ctl_i.walk && (ridx_q < count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ridx_q <= '0;
      rv_q   <= 1'b0;
    end else if (ctl_i.load) begin
      ridx_q <= '0;
      rv_q   <= 1'b0;
    end else if (ctl_i.shift_init) begin
      ridx_q <= CntW'(best_idx_q) + CntW'(1);
      rv_q   <= 1'b0;
    end else begin
      rv_q <= issue;
      if (issue) ridx_q <= ridx_q + CntW'(1);
    end
  end

  logic            q_we;
  logic [QW-1:0]   q_waddr;
  smq_pkg::qent_t  q_wdata;
  logic            q_commit;

  assign q_commit = ctl_i.commit && (ctl_i.kind == smq_pkg::CmQueue);

  always_comb begin
    q_we    = 1'b0;
    q_waddr = pos_q - QW'(1);
    q_wdata = rdata_q;
    if (q_commit) begin
      q_we    = 1'b1;
      q_waddr = count_q[QW-1:0];
      q_wdata = '{tbl: item_q.table_id, score: score_q};
    end else if (rv_q && ctl_i.shift) begin
      q_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rdata_q <= q_mem[ridx_q[QW-1:0]];
      pos_q   <= ridx_q[QW-1:0];
    end
    if (q_we) q_mem[q_waddr] <= q_wdata;
    if (rv_q && !ctl_i.shift) begin
      if (pos_q == '0 || rdata_q.score > best_score_q) begin
        best_score_q <= rdata_q.score;
        best_tab_q   <= rdata_q.tbl;
        best_idx_q   <= pos_q;
      end
    end
  end

  // registered reads of the table's flags and last run time
  always_ff @(posedge clk_i) begin
    lrt_rd_q  <= lrt_mem[tidx];
    pend_rd_q <= pend_q[tidx];
    run_rd_q  <= run_q[tidx];
    if (ctl_i.commit && (ctl_i.kind == smq_pkg::CmQueue || ctl_i.kind == smq_pkg::CmFinish))
      lrt_mem[tidx] <= item_q.now_sec;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_COUNT; i++) begin
        pend_q[i] <= 1'b0;
        run_q[i]  <= 1'b0;
      end
    end else if (ctl_i.commit) begin
      case (ctl_i.kind)
        smq_pkg::CmQueue: begin
          pend_q[tidx] <= 1'b1;
          run_q[tidx]  <= 1'b1;
        end
        smq_pkg::CmFinish: run_q[tidx] <= 1'b1;
        smq_pkg::CmTake:   pend_q[mod_lut[best_tab_q]] <= 1'b0;
        default: ;
      endcase
    end
  end

  // depth bookkeeping
  always_comb begin
    count_d = count_q;
    case (ctl_i.kind)
      smq_pkg::CmQueue: count_d = count_q + CntW'(1);
      smq_pkg::CmTake:  count_d = count_q - CntW'(1);
      default:          count_d = count_q;
    endcase
    peak_d = (count_d > peak_q) ? count_d : peak_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      peak_q  <= '0;
    end else if (ctl_i.commit) begin
      count_q <= count_d;
      peak_q  <= peak_d;
    end
  end

  // result register
  logic out_valid_q;
  smq_pkg::out_item_t out_q, res;

  always_comb begin
    res             = '0;
    res.out_table   = item_q.table_id;
    res.queue_depth = 9'(count_d);
    res.depth_peak  = 9'(peak_d);
    case (ctl_i.kind)
      smq_pkg::CmQueue: begin
        res.status     = smq_pkg::StQueued;
        res.out_score  = score_q;
        res.bonus_term = bonus_q;
        res.gap_term   = gap_q[30:0];
      end
      smq_pkg::CmRefuse: res.status = trig_code;
      smq_pkg::CmTake: begin
        res.status    = smq_pkg::StDispatched;
        res.out_table = best_tab_q;
        res.out_score = best_score_q;
      end
      smq_pkg::CmEmpty:  res.status = smq_pkg::StEmpty;
      smq_pkg::CmFinish: res.status = smq_pkg::StFinished;
      default:           res.status = smq_pkg::StEmpty;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.commit) out_q <= res;
  end

  assign out_item_o  = out_q;
  assign out_valid_o = out_valid_q;

  assign sts_o.cmd       = item_q.cmd;
  assign sts_o.trig_ok   = (trig_code == smq_pkg::StQueued);
  assign sts_o.q_empty   = (count_q == '0);
  assign sts_o.walk_done = (ridx_q == count_q) && !rv_q;
  assign sts_o.out_busy  = out_valid_q && !out_ready_i;

  `SMQ_ASSERT(a_count_range, count_q <= CntW'(QUEUE_DEPTH), "queue count beyond depth")
  `SMQ_ASSERT(a_peak_cover, peak_q >= count_q, "peak below current depth")
  `SMQ_ASSERT_IMP(a_take_nonempty, ctl_i.commit && ctl_i.kind == smq_pkg::CmTake,
                  count_q != '0, "dispatch from an empty queue")

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the scored maintenance queue: random and directed
// trigger, take and finish beats, a predicting scoreboard, random back-pressure.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [1:0] CmdUnused = 2'd3;
  localparam int WatchLimit = 20000;
  localparam int SettleCycles = 600;

  // Predicts each result from its own copy of the queue, the table marks
  // and the register settings, and checks results in arrival order.
  class queue_scoreboard;
    logic [15:0] min_int;
    logic [8:0]  cap;
    bit          use_h;
    logic [31:0] weight;
    bit          gap_en;
    logic [7:0]  ent_tbl[256];
    logic [63:0] ent_scr[256];
    int unsigned depth, peak;
    bit          pend[256];
    bit          ran[256];
    logic [31:0] last_t[256];
    smq_pkg::out_item_t want_q[$];
    int unsigned errors, checked;
    int unsigned st_seen[8];

    function new();
      min_int = 0; cap = 256; use_h = 0; weight = 65536; gap_en = 0;
      depth = 0; peak = 0; errors = 0; checked = 0;
      foreach (pend[i]) begin
        pend[i] = 0; ran[i] = 0; last_t[i] = 0;
      end
      foreach (st_seen[i]) st_seen[i] = 0;
    endfunction

    function void write_reg(logic [smq_pkg::CfgIdxW-1:0] idx,
                            logic [smq_pkg::CfgDataW-1:0] v);
      case (idx)
        smq_pkg::RegMinInterval: min_int = v[15:0];
        smq_pkg::RegQueueCap:    cap = v[8:0];
        smq_pkg::RegUseHealth:   use_h = v[0];
        smq_pkg::RegSlotWeight:  weight = v;
        smq_pkg::RegGapEnable:   gap_en = v[0];
        default: ;
      endcase
    endfunction

    function logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? '1 : s[63:0];
    endfunction

    function void note_request(smq_pkg::in_item_t it);
      smq_pkg::out_item_t w;
      int          t, best, lim;
      logic [31:0] wt;
      logic [63:0] prod, diff;
      t = it.table_id;
      if (it.cmd == CmdUnused) return;
      w = '0;
      w.out_table = it.table_id;
      if (it.cmd == smq_pkg::CmdTrigger) begin
        lim = (cap == 0 || cap > 256) ? 256 : cap;
        if (ran[t] && min_int != 0 && it.now_sec >= last_t[t] &&
            (it.now_sec - last_t[t]) < {16'd0, min_int}) begin
          w.status = smq_pkg::StCooldown;
        end else if (pend[t]) begin
          w.status = smq_pkg::StPending;
        end else if (depth >= lim) begin
          w.status = smq_pkg::StFull;
        end else begin
          w.out_score = it.size_bytes;
          if (use_h && it.health_valid) begin
            wt = (weight == 0) ? smq_pkg::DefaultWeight : weight;
            prod = 64'(it.tomb_slots) * 64'(wt);
            w.bonus_term = add_sat(add_sat(it.dead_space, prod), 64'(it.tomb_ratio_micro));
            w.out_score = add_sat(it.size_bytes, w.bonus_term);
            if (gap_en && it.lsn_now != 0 && it.lsn_last_vac != 0 &&
                it.lsn_now > it.lsn_last_vac) begin
              diff = it.lsn_now - it.lsn_last_vac;
              if (diff > smq_pkg::GapCap) diff = smq_pkg::GapCap;
              w.gap_term = diff[30:0];
              w.out_score = add_sat(w.out_score, diff);
            end
          end
          pend[t] = 1; ran[t] = 1; last_t[t] = it.now_sec;
          ent_tbl[depth] = it.table_id;
          ent_scr[depth] = w.out_score;
          depth++;
          if (depth > peak) peak = depth;
          w.status = smq_pkg::StQueued;
        end
      end else if (it.cmd == smq_pkg::CmdTake) begin
        if (depth == 0) begin
          w.status = smq_pkg::StEmpty;
        end else begin
          best = 0;
          for (int i = 1; i < depth; i++)
            if (ent_scr[i] > ent_scr[best]) best = i;
          w.out_table = ent_tbl[best];
          w.out_score = ent_scr[best];
          for (int i = best; i + 1 < depth; i++) begin
            ent_tbl[i] = ent_tbl[i+1];
            ent_scr[i] = ent_scr[i+1];
          end
          depth--;
          pend[w.out_table] = 0;
          w.status = smq_pkg::StDispatched;
        end
      end else begin
        ran[t] = 1; last_t[t] = it.now_sec;
        w.status = smq_pkg::StFinished;
      end
      w.queue_depth = depth[8:0];
      w.depth_peak = peak[8:0];
      st_seen[w.status]++;
      want_q = {want_q, w};
    endfunction

    function void check_result(smq_pkg::out_item_t got);
      smq_pkg::out_item_t w;
      checked++;
      if (want_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat: %p", got);
        return;
      end
      w = want_q.pop_front();
      if (got.status !== w.status || got.out_table !== w.out_table ||
          got.out_score !== w.out_score || got.bonus_term !== w.bonus_term ||
          got.gap_term !== w.gap_term || got.queue_depth !== w.queue_depth ||
          got.depth_peak !== w.depth_peak) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch at result %0d", checked);
          $display("  expected st=%0d tbl=%0d score=%h bonus=%h gap=%h depth=%0d peak=%0d",
                   w.status, w.out_table, w.out_score, w.bonus_term, w.gap_term,
                   w.queue_depth, w.depth_peak);
          $display("  actual   st=%0d tbl=%0d score=%h bonus=%h gap=%h depth=%0d peak=%0d",
                   got.status, got.out_table, got.out_score, got.bonus_term, got.gap_term,
                   got.queue_depth, got.depth_peak);
        end
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_we_i = 0;
  logic [smq_pkg::CfgIdxW-1:0] cfg_idx_i = '0;
  logic [smq_pkg::CfgDataW-1:0] cfg_data_i = '0;
  logic in_valid_i = 0;
  logic in_ready_o;
  smq_pkg::in_item_t in_item_i = '0;
  logic out_valid_o;
  logic out_ready_i = 0;
  smq_pkg::out_item_t out_item_o;

  queue_scoreboard sb = new();
  bit idle_on = 1;          // random idle bursts on both sides
  int rx_hold = 0;          // long receiver hold-off, counted down below
  int rx_wait = 0;
  int quiet = 0;
  int unsigned beats_in = 0;
  logic [31:0] now_ctr = 0;

  scored_maintenance_queue_unit uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .in_item_i,
    .out_valid_o, .out_ready_i, .out_item_o
  );

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  // Receiver: hold off for a long stretch on request, else idle in bursts.
  always @(negedge clk_i) begin
    if (rx_hold > 0) begin
      out_ready_i <= 0;
      rx_hold--;
    end else if (rx_wait > 0) begin
      out_ready_i <= 0;
      rx_wait--;
    end else begin
      out_ready_i <= 1;
      if (idle_on && $urandom_range(0, 9) == 0) rx_wait = $urandom_range(1, 18);
    end
  end

  // Note every accepted beat, check every result beat, and watch for a hang.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        sb.note_request(in_item_i);
        beats_in++;
      end
      if (out_valid_o && out_ready_i) sb.check_result(out_item_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
      if (quiet >= WatchLimit) begin
        $display("timeout: no beat for %0d cycles", WatchLimit);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // Offer one beat; called and returning at a falling edge.
  task automatic send(smq_pkg::in_item_t it);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 0;
      repeat ($urandom_range(1, 18)) @(negedge clk_i);
    end
    in_valid_i <= 1;
    in_item_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // Stop offering and wait until every expected result is back.
  task automatic drain();
    in_valid_i <= 0;
    do @(posedge clk_i); while (sb.want_q.size() != 0);
    @(negedge clk_i);
  endtask

  // Write all registers while idle; an unused-command beat may still be in flight.
  task automatic set_regs(logic [15:0] mi, logic [8:0] cp, bit uh, logic [31:0] wt, bit ge);
    drain();
    repeat (SettleCycles) @(negedge clk_i);
    cfg_we_i <= 1; cfg_idx_i <= smq_pkg::RegMinInterval; cfg_data_i <= 32'(mi);
    @(negedge clk_i);
    cfg_idx_i <= smq_pkg::RegQueueCap; cfg_data_i <= 32'(cp);
    @(negedge clk_i);
    cfg_idx_i <= smq_pkg::RegUseHealth; cfg_data_i <= 32'(uh);
    @(negedge clk_i);
    cfg_idx_i <= smq_pkg::RegSlotWeight; cfg_data_i <= wt;
    @(negedge clk_i);
    cfg_idx_i <= smq_pkg::RegGapEnable; cfg_data_i <= 32'(ge);
    @(negedge clk_i);
    cfg_we_i <= 0;
    sb.write_reg(smq_pkg::RegMinInterval, 32'(mi));
    sb.write_reg(smq_pkg::RegQueueCap, 32'(cp));
    sb.write_reg(smq_pkg::RegUseHealth, 32'(uh));
    sb.write_reg(smq_pkg::RegSlotWeight, wt);
    sb.write_reg(smq_pkg::RegGapEnable, 32'(ge));
    @(negedge clk_i);
  endtask

  function automatic smq_pkg::in_item_t mk(logic [1:0] c, logic [7:0] tb, logic [31:0] nw,
                                           logic [63:0] sz, bit hv, logic [63:0] dd,
                                           logic [31:0] sl, logic [19:0] ra,
                                           logic [63:0] lv, logic [63:0] ln);
    smq_pkg::in_item_t it;
    it.cmd = c; it.table_id = tb; it.now_sec = nw; it.size_bytes = sz;
    it.health_valid = hv; it.dead_space = dd; it.tomb_slots = sl;
    it.tomb_ratio_micro = ra; it.lsn_last_vac = lv; it.lsn_now = ln;
    return it;
  endfunction

  function automatic logic [63:0] rand64();
    logic [63:0] v;
    case ($urandom_range(0, 7))
      0: v = '1;
      1: v = '0;
      2: v = {$urandom, $urandom};
      default: v = {$urandom, $urandom} >> $urandom_range(8, 63);
    endcase
    return v;
  endfunction

  function automatic smq_pkg::in_item_t rand_item(int tbl_hi, int trig_pct, int take_pct);
    smq_pkg::in_item_t it;
    int r;
    r = $urandom_range(0, 99);
    if (r < trig_pct) it.cmd = smq_pkg::CmdTrigger;
    else if (r < trig_pct + take_pct) it.cmd = smq_pkg::CmdTake;
    else if (r < 96) it.cmd = smq_pkg::CmdFinish;
    else it.cmd = CmdUnused;
    it.table_id = 8'($urandom_range(0, tbl_hi));
    // mostly advancing time, now and then an arbitrary jump
    if ($urandom_range(0, 29) == 0) now_ctr = $urandom;
    else now_ctr += $urandom_range(0, 12);
    it.now_sec = now_ctr;
    it.size_bytes = rand64();
    it.health_valid = $urandom_range(0, 3) != 0;
    it.dead_space = rand64();
    it.tomb_slots = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 4000);
    it.tomb_ratio_micro = $urandom_range(0, 7) == 0 ? 20'($urandom)
                                                    : 20'($urandom_range(0, 1000000));
    it.lsn_last_vac = rand64();
    case ($urandom_range(0, 3))
      0: it.lsn_now = rand64();
      1: it.lsn_now = it.lsn_last_vac + {$urandom, $urandom} % 64'h8000_0000;
      default: it.lsn_now = it.lsn_last_vac + 64'($urandom_range(0, 5000));
    endcase
    return it;
  endfunction

  // Run n counted beats; unused-command beats are sent but not counted.
  task automatic run_random(int n, int tbl_hi, int trig_pct, int take_pct);
    smq_pkg::in_item_t it;
    int done;
    done = 0;
    while (done < n) begin
      it = rand_item(tbl_hi, trig_pct, take_pct);
      send(it);
      if (it.cmd != CmdUnused) done++;
    end
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    // Directed: capacity two, ten-second cooldown, every score term on.
    set_regs(16'd10, 9'd2, 1, 32'd0, 1);
    send(mk(smq_pkg::CmdTake, 8'hAB, 0, 0, 0, 0, 0, 0, 0, 0));             // empty queue
    send(mk(smq_pkg::CmdTrigger, 8'd1, 0, '1, 1, '1, '1, 20'd1000000, 1, 2)); // saturates
    send(mk(smq_pkg::CmdTrigger, 8'd1, 1, 5, 0, 0, 0, 0, 0, 0));           // cooldown, though also pending
    send(mk(smq_pkg::CmdTrigger, 8'd2, 1, 0, 0, '1, 0, 0, 0, 0));          // no health
    send(mk(smq_pkg::CmdTrigger, 8'd3, 1, 9, 0, 0, 0, 0, 0, 0));           // full
    send(mk(smq_pkg::CmdTake, 8'd0, 2, 0, 0, 0, 0, 0, 0, 0));
    send(mk(smq_pkg::CmdTrigger, 8'd1, 3, 9, 0, 0, 0, 0, 0, 0));           // cooldown
    send(mk(smq_pkg::CmdFinish, 8'd1, 100, 0, 0, 0, 0, 0, 0, 0));
    send(mk(smq_pkg::CmdTrigger, 8'd1, 105, 9, 0, 0, 0, 0, 0, 0));         // cooldown
    send(mk(smq_pkg::CmdTrigger, 8'd1, 50, 3, 1, 4, 7, 20'hFFFFF, 1,
            64'h100_0000_0000));                                           // time back, gap cap
    send(mk(smq_pkg::CmdTake, 8'd0, 51, 0, 0, 0, 0, 0, 0, 0));
    send(mk(smq_pkg::CmdTake, 8'd0, 51, 0, 0, 0, 0, 0, 0, 0));
    send(mk(smq_pkg::CmdTrigger, 8'd4, 60, 7, 0, 0, 0, 0, 0, 5));          // equal scores
    send(mk(smq_pkg::CmdTrigger, 8'd5, 60, 7, 1, 0, 0, 0, 0, 5));
    send(mk(smq_pkg::CmdTake, 8'd0, 61, 0, 0, 0, 0, 0, 0, 0));             // oldest wins
    send(mk(smq_pkg::CmdTake, 8'd0, 61, 0, 0, 0, 0, 0, 0, 0));
    send(mk(smq_pkg::CmdTrigger, 8'hFF, 70, '1, 1, 0, '1, 20'hFFFFF, 10, 5)); // lsn behind
    send(mk(smq_pkg::CmdTrigger, 8'h80, 70, 1, 1, 1, '1, 0, 64'h7FFF, '1));
    send(mk(CmdUnused, 8'h55, '1, '1, 1, '1, '1, 20'hFFFFF, '1, '1));
    send(mk(smq_pkg::CmdTake, 8'd0, 71, 0, 0, 0, 0, 0, 0, 0));
    send(mk(smq_pkg::CmdTake, 8'd0, 71, 0, 0, 0, 0, 0, 0, 0));
    send(mk(smq_pkg::CmdFinish, 8'hFF, '1, 0, 0, 0, 0, 0, 0, 0));

    set_regs(16'd0, 9'd3, 1, 32'd0, 1);
    run_random(300, 15, 50, 30);
    set_regs(16'hFFFF, 9'd0, 1, 32'hFFFF_FFFF, 1);
    run_random(300, 255, 50, 30);

    // Fill toward full depth; hold the receiver so the input stalls.
    set_regs(16'd5, 9'd256, 0, 32'd1, 0);
    rx_hold = 3000;
    run_random(350, 255, 85, 5);
    drain();
    run_random(100, 255, 10, 85);

    set_regs(16'd1, 9'd511, 1, 32'd65536, 0);
    run_random(300, 31, 45, 35);

    // Last stretch without idling on either side.
    set_regs(16'd100, 9'd1, 1, 32'd3, 1);
    idle_on = 0;
    run_random(200, 7, 45, 35);

    drain();
    repeat (SettleCycles) @(posedge clk_i);
    if (sb.want_q.size() != 0) sb.errors++;
    $display("covered %0d beats in, %0d results; queued %0d, cooldown %0d, pending %0d,",
             beats_in, sb.checked, sb.st_seen[smq_pkg::StQueued],
             sb.st_seen[smq_pkg::StCooldown], sb.st_seen[smq_pkg::StPending]);
    $display("  full %0d, dispatched %0d, empty %0d, finished %0d; peak depth %0d",
             sb.st_seen[smq_pkg::StFull], sb.st_seen[smq_pkg::StDispatched],
             sb.st_seen[smq_pkg::StEmpty], sb.st_seen[smq_pkg::StFinished], sb.peak);
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
